FILE: src/sws_pkg.sv
// Shared types, constants and control structs of the sliding window statistics block.
package sws_pkg;

  localparam int DEFAULT_DEPTH = 64;
  localparam logic [6:0] WINDOW_SIZE_RESET = 7'd64;
  localparam logic REG_WINDOW_SIZE = 1'b0;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               clear;
  } in_item_t;

  typedef struct packed {
    logic [6:0]         count;
    logic signed [23:0] mean_value;
    logic [23:0]        std_dev;
    logic signed [15:0] minimum;
    logic signed [15:0] maximum;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_PASS,
    ST_MDIV,
    ST_MUL,
    ST_VDIV,
    ST_SQRT,
    ST_OUT
  } sws_state_t;

  typedef struct packed {
    logic load;
    logic pass_start;
    logic mdiv_start;
    logic mean_take;
    logic mul_start;
    logic vdiv_start;
    logic sqrt_start;
    logic result_take;
  } sws_cmd_t;

  typedef struct packed {
    logic pass_done;
    logic div_done;
    logic mul_done;
    logic sqrt_done;
    logic out_free;
  } sws_status_t;

endpackage

FILE: src/sws_ctrl.sv
// Controller state machine that sequences the window pass, divisions, multiply and root.
module sws_ctrl
  import sws_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  sws_status_t status,
  output sws_cmd_t    cmd
);

  sws_state_t state, state_next;

  // hold the state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // advance through the phases of one item
  always_comb begin
    state_next = state;
    cmd = '0;
    in_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = ST_START;
        end
      end
      ST_START: begin
        cmd.pass_start = 1'b1;
        state_next = ST_PASS;
      end
      ST_PASS: begin
        if (status.pass_done) begin
          cmd.mdiv_start = 1'b1;
          state_next = ST_MDIV;
        end
      end
      ST_MDIV: begin
        if (status.div_done) begin
          cmd.mean_take = 1'b1;
          cmd.mul_start = 1'b1;
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        if (status.mul_done) begin
          cmd.vdiv_start = 1'b1;
          state_next = ST_VDIV;
        end
      end
      ST_VDIV: begin
        if (status.div_done) begin
          cmd.sqrt_start = 1'b1;
          state_next = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (status.sqrt_done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (status.out_free) begin
          cmd.result_take = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: src/sws_datapath.sv
// Datapath: sample store, window pass, shared divider, multiplier, square root, output register.
module sws_datapath
  import sws_pkg::*;
#(
  parameter int DEPTH = DEFAULT_DEPTH
)
(
  input  logic        clk,
  input  logic        rst,
  input  sws_cmd_t    cmd,
  output sws_status_t status,
  input  in_item_t    in_data,
  input  logic [6:0]  window_size,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data
);

  localparam int PTR_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CAP_W  = (CNT_W > 7) ? CNT_W : 7;
  localparam int SUM_W  = 16 + CNT_W;
  localparam int SQ_W   = 30 + CNT_W;
  localparam int S_W    = SQ_W + CNT_W;
  localparam int ASQ_W  = 2 * SUM_W;
  localparam int Q_W    = S_W + 16;
  localparam int DV_W   = 2 * CNT_W;
  localparam int LOW_W  = (Q_W < 64) ? Q_W : 64;
  localparam int RAD_W  = (LOW_W + 1) / 2 * 2;
  localparam int RT_W   = RAD_W / 2;
  localparam int DC_W   = $clog2(Q_W + 1);
  localparam int MC_W   = $clog2(CNT_W + 1);
  localparam int SC_W   = $clog2(RT_W + 1);

  logic [15:0] mem [DEPTH];
  logic [15:0] rdata;

  logic [PTR_W-1:0] wp;
  logic [CNT_W-1:0] held;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] left;
  logic             rd_vld;
  logic             first;

  logic signed [SUM_W-1:0] sum;
  logic [SQ_W-1:0]         sumsq;
  logic signed [15:0]      mn;
  logic signed [15:0]      mx;

  logic [Q_W-1:0]  dq;
  logic [DV_W-1:0] drem;
  logic [DV_W-1:0] dvs;
  logic [DC_W-1:0] dcnt;

  logic [S_W-1:0]   mcand;
  logic [CNT_W-1:0] mplier;
  logic [S_W-1:0]   prod;
  logic [S_W-1:0]   asq;
  logic [MC_W-1:0]  mcnt;

  logic [RAD_W-1:0] rx;
  logic [RT_W-1:0]  root;
  logic [RT_W:0]    srem;
  logic [SC_W-1:0]  scnt;

  logic [23:0] mean;

  // window capacity, clamped to one..DEPTH
  logic [CAP_W-1:0] ws_ext;
  logic [CAP_W-1:0] cap;
  always_comb begin
    ws_ext = CAP_W'(window_size);
    if (ws_ext == '0) begin
      cap = CAP_W'(1);
    end else if (ws_ext > CAP_W'(DEPTH)) begin
      cap = CAP_W'(DEPTH);
    end else begin
      cap = ws_ext;
    end
  end

  // store the sample on transfer
  always_ff @(posedge clk) begin
    if (cmd.load && !in_data.clear) begin
      mem[wp] <= in_data.sample;
    end
    if (left != '0) begin
      rdata <= mem[rd_ptr];
    end
  end

  // advance write pointer and held count, walk the window backward
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      held <= '0;
      left <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (cmd.load) begin
        if (in_data.clear) begin
          wp <= '0;
          held <= '0;
        end else begin
          wp <= (wp == PTR_W'(DEPTH - 1)) ? '0 : wp + 1'b1;
          if (CAP_W'(held) < cap) begin
            held <= held + 1'b1;
          end
        end
      end
      if (cmd.pass_start) begin
        left <= held;
        rd_ptr <= (wp == '0) ? PTR_W'(DEPTH - 1) : wp - 1'b1;
        rd_vld <= 1'b0;
      end else if (left != '0) begin
        left <= left - 1'b1;
        rd_ptr <= (rd_ptr == '0) ? PTR_W'(DEPTH - 1) : rd_ptr - 1'b1;
        rd_vld <= 1'b1;
      end else begin
        rd_vld <= 1'b0;
      end
    end
  end

  // accumulate sum, sum of squares and extremes
  logic signed [31:0] vv;
  assign vv = $signed(rdata) * $signed(rdata);

  always_ff @(posedge clk) begin
    if (cmd.pass_start) begin
      sum <= '0;
      sumsq <= '0;
      mn <= '0;
      mx <= '0;
      first <= 1'b1;
    end else if (rd_vld) begin
      sum <= sum + SUM_W'($signed(rdata));
      sumsq <= sumsq + SQ_W'(unsigned'(vv));
      first <= 1'b0;
      if (first || $signed(rdata) < mn) begin
        mn <= $signed(rdata);
      end
      if (first || $signed(rdata) > mx) begin
        mx <= $signed(rdata);
      end
    end
  end

  logic             sum_neg;
  logic [SUM_W-1:0] asum;
  logic [ASQ_W-1:0] asq_full;
  logic [S_W-1:0]   s_diff;
  logic [CNT_W-1:0] held_m1;
  assign sum_neg  = sum < 0;
  assign asum     = sum_neg ? SUM_W'(-sum) : SUM_W'(sum);
  assign asq_full = ASQ_W'(asum) * ASQ_W'(asum);
  assign s_diff   = prod - asq;
  assign held_m1  = held - 1'b1;

  // shared restoring divider, one quotient bit a cycle
  logic [DV_W:0] dtrial;
  assign dtrial = {drem, dq[Q_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      dcnt <= '0;
    end else if (cmd.mdiv_start) begin
      dq <= Q_W'({asum, 8'd0});
      dvs <= DV_W'(held);
      drem <= '0;
      dcnt <= DC_W'(Q_W);
    end else if (cmd.vdiv_start) begin
      dq <= {s_diff, 16'd0};
      dvs <= DV_W'(held) * DV_W'(held_m1);
      drem <= '0;
      dcnt <= DC_W'(Q_W);
    end else if (dcnt != '0) begin
      if (dtrial >= {1'b0, dvs}) begin
        drem <= DV_W'(dtrial - {1'b0, dvs});
        dq <= {dq[Q_W-2:0], 1'b1};
      end else begin
        drem <= dtrial[DV_W-1:0];
        dq <= {dq[Q_W-2:0], 1'b0};
      end
      dcnt <= dcnt - 1'b1;
    end
  end

  // take the floored mean
  always_ff @(posedge clk) begin
    if (cmd.mean_take) begin
      mean <= sum_neg ? (24'd0 - dq[23:0] - {23'd0, drem != '0}) : dq[23:0];
    end
  end

  // shift-add multiply of count by sum of squares
  always_ff @(posedge clk) begin
    if (rst) begin
      mcnt <= '0;
    end else if (cmd.mul_start) begin
      mcand <= S_W'(sumsq);
      mplier <= held;
      prod <= '0;
      asq <= S_W'(asq_full);
      mcnt <= MC_W'(CNT_W);
    end else if (mcnt != '0) begin
      if (mplier[0]) begin
        prod <= prod + mcand;
      end
      mcand <= {mcand[S_W-2:0], 1'b0};
      mplier <= mplier >> 1;
      mcnt <= mcnt - 1'b1;
    end
  end

  // integer square root, two radicand bits a cycle
  logic [RT_W+2:0] stest;
  logic [RT_W+2:0] strial;
  assign stest  = {srem, rx[RAD_W-1:RAD_W-2]};
  assign strial = {1'b0, root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      scnt <= '0;
    end else if (cmd.sqrt_start) begin
      rx <= RAD_W'(dq[LOW_W-1:0]);
      root <= '0;
      srem <= '0;
      scnt <= SC_W'(RT_W);
    end else if (scnt != '0) begin
      if (stest >= strial) begin
        srem <= (RT_W+1)'(stest - strial);
        root <= {root[RT_W-2:0], 1'b1};
      end else begin
        srem <= (RT_W+1)'(stest);
        root <= {root[RT_W-2:0], 1'b0};
      end
      rx <= {rx[RAD_W-3:0], 2'b00};
      scnt <= scnt - 1'b1;
    end
  end

  // hold the result until the transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.result_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.result_take) begin
      out_data.count <= 7'(held);
      out_data.mean_value <= (held == '0) ? '0 : $signed(mean);
      out_data.std_dev <= (held > CNT_W'(1)) ? root[23:0] : 24'd0;
      out_data.minimum <= (held == '0) ? '0 : mn;
      out_data.maximum <= (held == '0) ? '0 : mx;
    end
  end

  assign status.pass_done = (left == '0) && !rd_vld;
  assign status.div_done  = (dcnt == '0);
  assign status.mul_done  = (mcnt == '0);
  assign status.sqrt_done = (scnt == '0);
  assign status.out_free  = !out_valid || !out_stall;

`ifndef NO_ASSERTIONS
  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    cmd.load && in_data.clear |=> held == '0 && wp == '0)
    else $error("clear did not empty the window");

  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.load && !in_data.clear && CAP_W'(held) >= cap |=> $stable(held))
    else $error("held count grew at capacity");

  a_take_free: assert property (@(posedge clk) disable iff (rst)
    cmd.result_take |-> !out_valid || !out_stall)
    else $error("result overwrote a stalled output");

  a_div_start: assert property (@(posedge clk) disable iff (rst)
    cmd.mdiv_start || cmd.vdiv_start |=> dcnt == DC_W'(Q_W))
    else $error("divider did not start");
`endif

endmodule

FILE: src/sliding_window_statistics.sv
// Top level of the sliding window statistics block: configuration register, controller, datapath.
//
// Keeps up to window_size most recent signed 16-bit samples and returns, for every input
// transfer, count, floored mean (8 fraction bits), sample standard deviation (8 fraction
// bits), minimum and maximum. One item at a time is in work: a pass over the n held samples
// (one memory read a cycle), the mean division, the shift-add multiplier with C steps, the
// variance division and the square root unit with R steps, after which the item waits until
// the output register is free. The shared one-bit-a-cycle divider (used for the mean and for
// the variance) has Q = 46 + 2*C quotient bits, R = Q/2 rounded up (at most 32), and
// C = clog2(WINDOW_DEPTH+1). A finished result waits in the output register while the next
// item is accepted.
module sliding_window_statistics
  import sws_pkg::*;
#(
  parameter int WINDOW_DEPTH = DEFAULT_DEPTH
)
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [6:0]  window_size;
  sws_cmd_t    cmd;
  sws_status_t status;

  // write the configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WINDOW_SIZE_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_WINDOW_SIZE) begin
      window_size <= pwdata[6:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_WINDOW_SIZE) ? {25'd0, window_size} : 32'd0;

  sws_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  sws_datapath #(
    .DEPTH (WINDOW_DEPTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .in_data     (in_data),
    .window_size (window_size),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule
